[design/kfsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfsp_pkg: shared types and constants for the keyframe spline core
// Request and result payloads, control group, codes and fixed constants.
// ----------------------------------------------------------------------------
package kfsp_pkg;

  // Fixed field widths
  localparam int COORD_W     = 32;
  localparam int SLOT_W      = 4;
  localparam int KEY_COUNT_W = 5;
  localparam int CFG_W       = 5;
  localparam int TIME_W      = 17;
  localparam int TIME_FRAC   = 16;
  localparam int TIME_ONE    = 65536;

  // Reciprocal of three: floor(y * RECIP3 >> RECIP3_SHIFT) == floor(y / 3) for y < 2^33
  localparam logic [33:0] RECIP3       = 34'h2_AAAA_AAAB;
  localparam int          RECIP3_SHIFT = 35;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_EVAL  = 1'b1
  } req_type_e;

  typedef enum logic {
    MODE_CATMULL = 1'b0,
    MODE_BSPLINE = 1'b1
  } mode_e;

  typedef enum logic [0:0] {
    CFG_SPLINE_MODE = 1'b0,
    CFG_KEY_COUNT   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                       req_type;
    logic [SLOT_W-1:0]          key_slot;
    logic signed [COORD_W-1:0]  pos_x;
    logic signed [COORD_W-1:0]  pos_y;
    logic signed [COORD_W-1:0]  pos_z;
    logic [TIME_W-1:0]          time_param;
  } req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
  } res_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  // Control group that travels with each evaluate request
  typedef struct packed {
    logic  valid;
    logic  zero;
    mode_e mode;
  } ctrl_t;

endpackage

[design/kfsp_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfsp_ram: generic RAM, one write port, two registered read ports
// Read returns the contents before a write at the same edge.
// ----------------------------------------------------------------------------
module kfsp_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write one entry, read two
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[design/kfsp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfsp_front: time scaling, segment select and control point indices
// Two stages: capture time and key count, then segment, local time, indices.
// ----------------------------------------------------------------------------
module kfsp_front #(
  parameter int MAX_KEYS  = 16,
  parameter int FRAC_BITS = 16,
  localparam int KW       = $clog2(MAX_KEYS),
  localparam int UW       = FRAC_BITS + 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  logic [kfsp_pkg::TIME_W-1:0]         time_i,
  input  kfsp_pkg::mode_e                     mode_i,
  input  logic [kfsp_pkg::KEY_COUNT_W-1:0]    key_count_i,
  output kfsp_pkg::ctrl_t                     ctrl_o,
  output logic [UW-1:0]                       u_o,
  output logic [3:0][KW-1:0]                  idx_o
);

  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int SW = kfsp_pkg::TIME_W + NW;
  localparam int TF = kfsp_pkg::TIME_FRAC;

  // Stage 1 signals
  logic [kfsp_pkg::TIME_W-1:0] t_d, t_q;
  logic [NW-1:0]               n_d;
  logic [NW-1:0]               nm1_d, nm1_q;
  logic                        zero_d, zero_q;
  logic                        few_d, few_q;
  logic                        s1_valid_q;
  kfsp_pkg::mode_e             mode_q;

  // Stage 2 signals
  logic [SW-1:0]               scaled;
  logic [NW:0]                 seg_raw;
  logic [NW-1:0]               seg_max;
  logic [NW-1:0]               seg;
  logic [kfsp_pkg::TIME_W-1:0] loc;
  logic [UW-1:0]               u_d, u_q;
  logic [3:0][KW-1:0]          idx_d, idx_q;
  kfsp_pkg::ctrl_t             ctrl_d, ctrl_q;

  // Clamp time to one and key count to the table size
  always_comb begin
    if (time_i > kfsp_pkg::TIME_W'(kfsp_pkg::TIME_ONE)) begin
      t_d = kfsp_pkg::TIME_W'(kfsp_pkg::TIME_ONE);
    end else begin
      t_d = time_i;
    end
    if (32'(key_count_i) > MAX_KEYS) begin
      n_d = NW'(MAX_KEYS);
    end else begin
      n_d = NW'(key_count_i);
    end
    zero_d = (n_d == '0);
    few_d  = (n_d < NW'(2));
    nm1_d  = zero_d ? '0 : n_d - NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    nm1_q  <= nm1_d;
    zero_q <= zero_d;
    few_q  <= few_d;
    mode_q <= mode_i;
  end

  // Scale time, pick the segment and the four clamped indices
  always_comb begin
    int ii;
    scaled  = SW'(t_q) * SW'(nm1_q);
    seg_raw = scaled[SW-1:TF];
    seg_max = nm1_q - NW'(1);
    if (few_q) begin
      seg = '0;
    end else if (seg_raw > (NW+1)'(seg_max)) begin
      seg = seg_max;
    end else begin
      seg = NW'(seg_raw);
    end
    loc = kfsp_pkg::TIME_W'(scaled - (SW'(seg) << TF));
    if (few_q) begin
      u_d = '0;
    end else begin
      u_d = UW'((48'(loc) << FRAC_BITS) >> TF);
    end
    for (int k = 0; k < 4; k++) begin
      ii = int'(seg) - 1 + k;
      if (ii < 0) begin
        ii = 0;
      end
      if (ii > int'(nm1_q)) begin
        ii = int'(nm1_q);
      end
      idx_d[k] = KW'(ii);
    end
    ctrl_d.valid = s1_valid_q;
    ctrl_d.zero  = zero_q;
    ctrl_d.mode  = few_q ? kfsp_pkg::MODE_CATMULL : mode_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    idx_q <= idx_d;
  end

  assign ctrl_o = ctrl_q;
  assign u_o    = u_q;
  assign idx_o  = idx_q;

endmodule

[design/kfsp_basis.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfsp_basis: powers of the local time and the four blend weights
// Three stages: squares, cubes, then Catmull-Rom or B-spline weights.
// ----------------------------------------------------------------------------
module kfsp_basis #(
  parameter int FRAC_BITS = 16,
  localparam int UW       = FRAC_BITS + 1,
  localparam int WW       = FRAC_BITS + 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kfsp_pkg::ctrl_t      ctrl_i,
  input  logic [UW-1:0]        u_i,
  output kfsp_pkg::ctrl_t      ctrl_o,
  output logic signed [WW-1:0] w_o [4]
);

  localparam logic [UW-1:0]   ONE   = UW'(1) << FRAC_BITS;
  localparam logic [2*UW-1:0] HALF  = (2*UW)'(1) << (FRAC_BITS - 1);
  localparam logic signed [WW-1:0] ONE_S = WW'(1) << FRAC_BITS;

  // Product rounded half up back to Q1.FRAC_BITS
  function automatic logic [UW-1:0] rmul(input logic [UW-1:0] a, input logic [UW-1:0] b);
    logic [2*UW-1:0] p;
    p = (2*UW)'(a) * (2*UW)'(b) + HALF;
    return UW'(p >> FRAC_BITS);
  endfunction

  kfsp_pkg::ctrl_t c3_q, c4_q, c5_q;
  logic [UW-1:0]   v;
  logic [UW-1:0]   u3_u_q, u3_u2_q, u3_v_q, u3_v2_q;
  logic [UW-1:0]   u4_u_q, u4_u2_q, u4_u3_q, u4_v3_q;
  logic signed [WW-1:0] su, su2, su3, sv3;
  logic signed [WW-1:0] w_d [4];
  logic signed [WW-1:0] w_q [4];

  assign v = ONE - u_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_q <= '0;
      c4_q <= '0;
      c5_q <= '0;
    end else begin
      c3_q <= ctrl_i;
      c4_q <= c3_q;
      c5_q <= c4_q;
    end
  end

  // Square u and v, then cube them
  always_ff @(posedge clk_i) begin
    u3_u_q  <= u_i;
    u3_u2_q <= rmul(u_i, u_i);
    u3_v_q  <= v;
    u3_v2_q <= rmul(v, v);
    u4_u_q  <= u3_u_q;
    u4_u2_q <= u3_u2_q;
    u4_u3_q <= rmul(u3_u2_q, u3_u_q);
    u4_v3_q <= rmul(u3_v2_q, u3_v_q);
  end

  // Blend weights from shifts and adds
  always_comb begin
    su  = WW'(u4_u_q);
    su2 = WW'(u4_u2_q);
    su3 = WW'(u4_u3_q);
    sv3 = WW'(u4_v3_q);
    if (c4_q.mode == kfsp_pkg::MODE_BSPLINE) begin
      w_d[0] = sv3;
      w_d[1] = (su3 <<< 1) + su3 - (su2 <<< 2) - (su2 <<< 1) + (ONE_S <<< 2);
      w_d[2] = (su2 <<< 1) + su2 - (su3 <<< 1) - su3 + (su <<< 1) + su + ONE_S;
      w_d[3] = su3;
    end else begin
      w_d[0] = (su2 <<< 1) - su - su3;
      w_d[1] = (ONE_S <<< 1) - (su2 <<< 2) - su2 + (su3 <<< 1) + su3;
      w_d[2] = su + (su2 <<< 2) - (su3 <<< 1) - su3;
      w_d[3] = su3 - su2;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  assign ctrl_o = c5_q;
  assign w_o    = w_q;

endmodule

[design/kfsp_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfsp_blend: weighted sum of four control points for one coordinate
// Five stages: products, sum, rounding, reciprocal products, saturation.
// ----------------------------------------------------------------------------
module kfsp_blend #(
  parameter int FRAC_BITS = 16,
  localparam int WW       = FRAC_BITS + 5
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  kfsp_pkg::ctrl_t                         ctrl_i,
  input  logic signed [WW-1:0]                    w_i [4],
  input  logic signed [kfsp_pkg::COORD_W-1:0]     p_i [4],
  output logic                                    vld_o,
  output logic signed [kfsp_pkg::COORD_W-1:0]     coord_o
);

  localparam int PW = WW + kfsp_pkg::COORD_W;
  localparam int AW = PW + 2;
  localparam int OW = AW + 1;
  localparam logic signed [OW-1:0] RND_CR = OW'(1) << FRAC_BITS;
  localparam logic signed [OW-1:0] RND_BS = OW'(3) << FRAC_BITS;
  localparam logic [OW-1:0]        LIM_CR = OW'(1) << 31;
  localparam logic [OW-1:0]        LIM_BS = OW'(3) << 31;

  kfsp_pkg::ctrl_t c1_q, c2_q, c3_q, c4_q;
  logic neg3_q, neg4_q;

  logic signed [PW-1:0] prod_q [4];
  logic signed [AW-1:0] acc_d, acc_q;
  logic signed [OW-1:0] accx, rnd, offs;
  logic [OW-1:0]        shv, lim;
  logic [32:0]          clip_d, clip_q;
  logic [50:0]          pl_q;
  logic [49:0]          ph_q;
  logic [31:0]          qcr_q;
  logic [67:0]          recip_sum;
  logic [31:0]          qb, q;
  logic signed [kfsp_pkg::COORD_W-1:0] coord_d, coord_q;
  logic                 vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q  <= '0;
      c2_q  <= '0;
      c3_q  <= '0;
      c4_q  <= '0;
      vld_q <= 1'b0;
    end else begin
      c1_q  <= ctrl_i;
      c2_q  <= c1_q;
      c3_q  <= c2_q;
      c4_q  <= c3_q;
      vld_q <= c4_q.valid;
    end
  end

  // Multiply each weight by its control point
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      prod_q[k] <= PW'(w_i[k]) * PW'(p_i[k]);
    end
  end

  // Sum the four products
  assign acc_d = AW'(prod_q[0]) + AW'(prod_q[1]) + AW'(prod_q[2]) + AW'(prod_q[3]);

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Round the magnitude and drop the common power of two; clip to the saturation range
  always_comb begin
    accx = OW'(acc_q);
    rnd  = (c2_q.mode == kfsp_pkg::MODE_BSPLINE) ? RND_BS : RND_CR;
    lim  = (c2_q.mode == kfsp_pkg::MODE_BSPLINE) ? LIM_BS : LIM_CR;
    offs = acc_q[AW-1] ? (rnd - accx) : (accx + rnd);
    shv  = offs >> (FRAC_BITS + 1);
    clip_d = (shv > lim) ? 33'(lim) : 33'(shv);
  end

  always_ff @(posedge clk_i) begin
    clip_q <= clip_d;
    neg3_q <= acc_q[AW-1];
  end

  // Divide by three as two partial products with the reciprocal
  always_ff @(posedge clk_i) begin
    pl_q   <= 51'(clip_q[16:0]) * 51'(kfsp_pkg::RECIP3);
    ph_q   <= 50'(clip_q[32:17]) * 50'(kfsp_pkg::RECIP3);
    qcr_q  <= clip_q[31:0];
    neg4_q <= neg3_q;
  end

  // Combine, apply sign and saturate
  always_comb begin
    recip_sum = (68'(ph_q) << 17) + 68'(pl_q);
    qb = 32'(recip_sum >> kfsp_pkg::RECIP3_SHIFT);
    q  = (c4_q.mode == kfsp_pkg::MODE_BSPLINE) ? qb : qcr_q;
    if (c4_q.zero) begin
      coord_d = '0;
    end else if (neg4_q) begin
      coord_d = -q;
    end else if (q[31]) begin
      coord_d = 32'h7FFF_FFFF;
    end else begin
      coord_d = q;
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
  end

  assign vld_o   = vld_q;
  assign coord_o = coord_q;

endmodule

[design/keyframe_spline_position_interp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_spline_position_interp_core: keyframe spline position interpolator
// Key table write, Catmull-Rom / uniform cubic B-spline evaluation.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Transfer
//  request   start, busy, req_i             edge with start high, busy low
//  result    done_o, res_o                  one cycle with done_o high
//  config    cfg_we_i, cfg_idx_i, cfg_wdata_i  edge with cfg_we_i high
//
//  One request per cycle. An evaluate request passes ten register stages (two
//  for time, three for the basis, five for the blend) before done_o goes
//  high for it.
//  A write request gives no result; it is registered, then lands in the key table at the next edge.
//  busy stays low: nothing in the pipeline ever holds.
//  Reset clears the pipeline valid bits and both configuration registers;
//  the key table is not cleared.
// ----------------------------------------------------------------------------
module keyframe_spline_position_interp_core #(
  parameter int MAX_KEYS  = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  kfsp_pkg::req_t                   req_i,
  output logic                             done_o,
  output kfsp_pkg::res_t                   res_o,
  input  logic                             cfg_we_i,
  input  logic [0:0]                       cfg_idx_i,
  input  logic [kfsp_pkg::CFG_W-1:0]       cfg_wdata_i
);

  localparam int KW = $clog2(MAX_KEYS);
  localparam int UW = FRAC_BITS + 1;
  localparam int WW = FRAC_BITS + 5;
  localparam int PTW = $bits(kfsp_pkg::point_t);

  logic accept;
  logic eval_go;
  logic wr_go;

  kfsp_pkg::mode_e                   mode_q;
  logic [kfsp_pkg::KEY_COUNT_W-1:0]  key_count_q;

  logic                 wr_valid_q;
  logic [KW-1:0]        wr_addr_q;
  kfsp_pkg::point_t     wr_data_q;

  kfsp_pkg::ctrl_t      ctrl_s2, ctrl_s5;
  logic [UW-1:0]        u_s2;
  logic [3:0][KW-1:0]   idx_s2;
  logic signed [WW-1:0] w_s5 [4];

  logic [PTW-1:0]       rd_data [4];
  kfsp_pkg::point_t     pts_s4_q [4];
  kfsp_pkg::point_t     pts_s5_q [4];
  logic signed [kfsp_pkg::COORD_W-1:0] px [4];
  logic signed [kfsp_pkg::COORD_W-1:0] py [4];
  logic signed [kfsp_pkg::COORD_W-1:0] pz [4];

  logic                 vx, vy, vz;
  logic signed [kfsp_pkg::COORD_W-1:0] cx, cy, cz;

  // Request decode
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign eval_go = accept && (req_i.req_type == kfsp_pkg::REQ_EVAL);
  assign wr_go   = accept && (req_i.req_type == kfsp_pkg::REQ_WRITE)
                   && (32'(req_i.key_slot) < MAX_KEYS);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= kfsp_pkg::MODE_CATMULL;
      key_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (kfsp_pkg::cfg_idx_e'(cfg_idx_i))
        kfsp_pkg::CFG_SPLINE_MODE: mode_q      <= kfsp_pkg::mode_e'(cfg_wdata_i[0]);
        kfsp_pkg::CFG_KEY_COUNT:   key_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Register a key write so earlier evaluations read the old entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else begin
      wr_valid_q <= wr_go;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q   <= KW'(req_i.key_slot);
    wr_data_q.x <= req_i.pos_x;
    wr_data_q.y <= req_i.pos_y;
    wr_data_q.z <= req_i.pos_z;
  end

  // Time scaling and indices
  kfsp_front #(
    .MAX_KEYS  (MAX_KEYS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (eval_go),
    .time_i      (req_i.time_param),
    .mode_i      (mode_q),
    .key_count_i (key_count_q),
    .ctrl_o      (ctrl_s2),
    .u_o         (u_s2),
    .idx_o       (idx_s2)
  );

  // Key table: two copies give four read ports
  kfsp_ram #(
    .WIDTH (PTW),
    .DEPTH (MAX_KEYS)
  ) u_ram_lo (
    .clk_i     (clk_i),
    .we_i      (wr_valid_q),
    .waddr_i   (wr_addr_q),
    .wdata_i   (wr_data_q),
    .raddr_a_i (idx_s2[0]),
    .raddr_b_i (idx_s2[1]),
    .rdata_a_o (rd_data[0]),
    .rdata_b_o (rd_data[1])
  );

  kfsp_ram #(
    .WIDTH (PTW),
    .DEPTH (MAX_KEYS)
  ) u_ram_hi (
    .clk_i     (clk_i),
    .we_i      (wr_valid_q),
    .waddr_i   (wr_addr_q),
    .wdata_i   (wr_data_q),
    .raddr_a_i (idx_s2[2]),
    .raddr_b_i (idx_s2[3]),
    .rdata_a_o (rd_data[2]),
    .rdata_b_o (rd_data[3])
  );

  // Basis weights
  kfsp_basis #(
    .FRAC_BITS (FRAC_BITS)
  ) u_basis (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_s2),
    .u_i    (u_s2),
    .ctrl_o (ctrl_s5),
    .w_o    (w_s5)
  );

  // Delay control points to line up with the weights
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      pts_s4_q[k] <= kfsp_pkg::point_t'(rd_data[k]);
      pts_s5_q[k] <= pts_s4_q[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px[k] = pts_s5_q[k].x;
      py[k] = pts_s5_q[k].y;
      pz[k] = pts_s5_q[k].z;
    end
  end

  // One blend pipeline per coordinate
  kfsp_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_s5),
    .w_i     (w_s5),
    .p_i     (px),
    .vld_o   (vx),
    .coord_o (cx)
  );

  kfsp_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_s5),
    .w_i     (w_s5),
    .p_i     (py),
    .vld_o   (vy),
    .coord_o (cy)
  );

  kfsp_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl_s5),
    .w_i     (w_s5),
    .p_i     (pz),
    .vld_o   (vz),
    .coord_o (cz)
  );

  // Result
  assign done_o      = vx & vy & vz;
  assign res_o.out_x = cx;
  assign res_o.out_y = cy;
  assign res_o.out_z = cz;

endmodule

[tb/keyframe_spline_position_interp_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_spline_position_interp_core_tb: self-checking bench for the core
// Fills the key table and evaluates the spline across Catmull-Rom, B-spline,
// key counts from zero to beyond the table size, and times past 1.0. A local
// fixed-point predictor computes each expected point; every result is checked
// field by field, in order, against the oldest outstanding evaluation.
// ----------------------------------------------------------------------------
module keyframe_spline_position_interp_core_tb;
  import kfsp_pkg::*;

  localparam int     MAX_KEYS  = 16;
  localparam int     FRAC_BITS = 16;
  localparam longint UNIT      = longint'(1) << FRAC_BITS;
  localparam int     N_PHASES  = 9;
  localparam int     PHASE_LEN = 215;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 req_i = '0;
  logic                 done_o;
  res_t                 res_o;
  logic                 cfg_we_i = 1'b0;
  logic [0:0]           cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  // Requests waiting to be issued and points still owed by the core
  req_t                 req_backlog[$];
  res_t                 expected_points[$];
  int                   idle_pct = 27;
  int                   err_count = 0;

  // Predictor copy of the key table and configuration
  point_t               key_tab[MAX_KEYS];
  mode_e                cfg_mode;
  logic [KEY_COUNT_W-1:0] cfg_count;

  always #6 clk_i = ~clk_i;

  keyframe_spline_position_interp_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Multiply two Q0.F values, round half up
  function automatic longint round_mul(longint a, longint b);
    return (a * b + (UNIT >> 1)) >>> FRAC_BITS;
  endfunction

  // Divide with rounding half away from zero, then clamp to 32 bits
  function automatic logic signed [COORD_W-1:0] round_sat(longint acc, longint div);
    longint mag;
    longint q;
    mag = (acc < 0) ? -acc : acc;
    q = (mag + div / 2) / div;
    if (acc < 0) begin
      return (q > 64'sd2147483648) ? 32'sh8000_0000 : 32'(-q);
    end
    return (q > 64'sd2147483647) ? 32'sh7fff_ffff : 32'(q);
  endfunction

  // Expected curve position for one evaluate request
  function automatic res_t spline_point(logic [TIME_W-1:0] t_raw);
    longint n, t, scaled, seg, u, u2, u3, v, v2, v3, div, i;
    longint ax, ay, az;
    longint w[4];
    int     idx[4];
    res_t   r;
    r = '0;
    n = (cfg_count > MAX_KEYS) ? MAX_KEYS : cfg_count;
    if (n == 0) begin
      return r;
    end
    if (n == 1) begin
      r.out_x = key_tab[0].x;
      r.out_y = key_tab[0].y;
      r.out_z = key_tab[0].z;
      return r;
    end
    // Split scaled time into segment and local time (F equals the time fraction)
    t = (t_raw > TIME_ONE) ? TIME_ONE : t_raw;
    scaled = t * (n - 1);
    seg = scaled >>> TIME_FRAC;
    if (seg > n - 2) seg = n - 2;
    u = scaled - (seg << TIME_FRAC);
    for (int k = 0; k < 4; k++) begin
      i = seg - 1 + k;
      if (i < 0) i = 0;
      if (i > n - 1) i = n - 1;
      idx[k] = int'(i);
    end
    u2 = round_mul(u, u);
    u3 = round_mul(u2, u);
    if (cfg_mode == MODE_CATMULL) begin
      w[0] = -u + 2 * u2 - u3;
      w[1] = 2 * UNIT - 5 * u2 + 3 * u3;
      w[2] = u + 4 * u2 - 3 * u3;
      w[3] = u3 - u2;
      div  = 2 * UNIT;
    end else begin
      v  = UNIT - u;
      v2 = round_mul(v, v);
      v3 = round_mul(v2, v);
      w[0] = v3;
      w[1] = 3 * u3 - 6 * u2 + 4 * UNIT;
      w[2] = -3 * u3 + 3 * u2 + 3 * u + UNIT;
      w[3] = u3;
      div  = 6 * UNIT;
    end
    ax = 0;
    ay = 0;
    az = 0;
    for (int k = 0; k < 4; k++) begin
      ax += w[k] * longint'(key_tab[idx[k]].x);
      ay += w[k] * longint'(key_tab[idx[k]].y);
      az += w[k] * longint'(key_tab[idx[k]].z);
    end
    r.out_x = round_sat(ax, div);
    r.out_y = round_sat(ay, div);
    r.out_z = round_sat(az, div);
    return r;
  endfunction

  // Random coordinate: extremes, small magnitudes or full range
  function automatic logic signed [COORD_W-1:0] rand_coord();
    logic [19:0] s;
    s = 20'($urandom());
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1:       return {{12{s[19]}}, s};
      default: return 32'($urandom());
    endcase
  endfunction

  // Random curve time, weighted toward the ends and past 1.0
  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(9))
      0:       return '0;
      1:       return TIME_W'(TIME_ONE);
      2:       return TIME_W'($urandom_range(TIME_ONE + 1, 2 * TIME_ONE - 1));
      default: return TIME_W'($urandom_range(0, TIME_ONE));
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t r;
    r.req_type   = ($urandom_range(99) < 30) ? REQ_WRITE : REQ_EVAL;
    r.key_slot   = SLOT_W'($urandom());
    r.pos_x      = rand_coord();
    r.pos_y      = rand_coord();
    r.pos_z      = rand_coord();
    r.time_param = rand_time();
    return r;
  endfunction

  function automatic req_t eval_req(int t);
    req_t r;
    r = '0;
    r.req_type   = REQ_EVAL;
    r.time_param = TIME_W'(t);
    return r;
  endfunction

  // Append one request to the tail of the backlog
  task automatic queue_req(req_t r);
    req_backlog.insert(req_backlog.size(), r);
  endtask

  // Register write: one cycle with the write enable high
  task automatic cfg_write(cfg_idx_e idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Spare upper bits of the mode write carry noise
  task automatic set_config(mode_e mode, int count);
    cfg_write(CFG_SPLINE_MODE, {4'($urandom()), mode});
    cfg_write(CFG_KEY_COUNT, CFG_W'(count));
    @(negedge clk_i);
  endtask

  // Hold until every request is taken and every point has come back, then settle
  task automatic wait_idle();
    while (req_backlog.size() != 0 || start || expected_points.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (16) @(negedge clk_i);
  endtask

  // Issue requests from the backlog, idling at random
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else if (!start || !busy) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        req_i <= req_backlog.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Track config and table writes, predict points, check results
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    res_t want;
    if (!rst_ni) begin
      cfg_mode  = MODE_CATMULL;
      cfg_count = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SPLINE_MODE: cfg_mode  = mode_e'(cfg_wdata_i[0]);
          CFG_KEY_COUNT:   cfg_count = cfg_wdata_i;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (req_i.req_type == REQ_WRITE) begin
          key_tab[req_i.key_slot] = {req_i.pos_x, req_i.pos_y, req_i.pos_z};
        end else begin
          expected_points.insert(expected_points.size(),
                                 spline_point(req_i.time_param));
        end
      end
      if (done_o) begin
        if (expected_points.size() == 0) begin
          $error("result with no evaluate request outstanding");
          err_count++;
        end else begin
          want = expected_points.pop_front();
          if (res_o.out_x !== want.out_x) begin
            $error("out_x: expected %0d, got %0d", want.out_x, res_o.out_x);
            err_count++;
          end
          if (res_o.out_y !== want.out_y) begin
            $error("out_y: expected %0d, got %0d", want.out_y, res_o.out_y);
            err_count++;
          end
          if (res_o.out_z !== want.out_z) begin
            $error("out_z: expected %0d, got %0d", want.out_z, res_o.out_z);
            err_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    req_t        r;
    int          counts[N_PHASES];
    logic        modes[N_PHASES];
    counts = '{16, 2, 0, 31, 1, 7, 16, 12, 3};
    modes  = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    counts[5] = $urandom_range(2, 15);
    counts[7] = $urandom_range(0, 31);

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // No keys yet: origin
    queue_req(eval_req(0));
    // Fill every slot; keys alternate in pairs between the extremes to force clamping
    for (int k = 0; k < MAX_KEYS; k++) begin
      r = '0;
      r.req_type   = REQ_WRITE;
      r.key_slot   = SLOT_W'(k);
      r.pos_x      = (((k + 2) % 4) == 1 || ((k + 2) % 4) == 2) ? 32'sh7fff_ffff
                                                                : 32'sh8000_0000;
      r.pos_y      = ~r.pos_x;
      r.pos_z      = (k % 2) ? -(k << 16) : (k << 16);
      r.time_param = '1;
      queue_req(r);
    end
    // Time past one, still no keys in use
    queue_req(eval_req(2 * TIME_ONE - 1));

    // One key: key 0 unchanged
    wait_idle();
    set_config(MODE_BSPLINE, 1);
    queue_req(eval_req(12345));

    // Full table, Catmull-Rom: overshoot, end of curve, time past one
    wait_idle();
    set_config(MODE_CATMULL, MAX_KEYS);
    queue_req(eval_req(TIME_ONE / 2));
    queue_req(eval_req(TIME_ONE));
    queue_req(eval_req(2 * TIME_ONE - 1));

    // Key count above the table size acts as the table size
    wait_idle();
    set_config(MODE_BSPLINE, 31);
    queue_req(eval_req(TIME_ONE / 2));
    queue_req(eval_req(0));

    // Two keys: single segment
    wait_idle();
    set_config(MODE_CATMULL, 2);
    queue_req(eval_req(TIME_ONE / 2));

    // Random phases; sender idles 27%, then 52%, then not at all
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      set_config(mode_e'(modes[p]), counts[p]);
      idle_pct = (p < 3) ? 27 : (p < 6) ? 52 : 0;
      for (int i = 0; i < PHASE_LEN; i++) begin
        queue_req(rand_req());
        // Pause mid-phase until the pipeline drains
        if (p == 4 && i == PHASE_LEN / 2) wait_idle();
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[filelist.f]
design/kfsp_pkg.sv
design/kfsp_ram.sv
design/kfsp_front.sv
design/kfsp_basis.sv
design/kfsp_blend.sv
design/keyframe_spline_position_interp_core.sv
tb/keyframe_spline_position_interp_core_tb.sv
